// ===== rtl/dls_pkg.sv =====
// Shared types, constants and the exp table for the dense layer with softmax.
package dls_pkg;

    localparam int OUTPUTS_DEF = 16;
    localparam int INPUTS_DEF  = 64;

    localparam int IDX_W   = 10;
    localparam int VAL_W   = 16;
    localparam int LOGIT_W = 24;
    localparam int EXP_W   = 32;
    localparam int TOTAL_W = 40;
    localparam int PROB_W  = 16;
    localparam int NRN_W   = 4;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    typedef enum logic [1:0] {
        ACT_WEIGHT = 2'd0,
        ACT_BIAS   = 2'd1,
        ACT_ELEM   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_SHIFT,
        ST_DRAIN,
        ST_RD,
        ST_RDW,
        ST_DIV,
        ST_OUT
    } t_state;

    // Load port seen by every cell.
    typedef struct packed {
        logic               wen_w;
        logic               wen_b;
        logic [IDX_W-1:0]   index;
        logic [VAL_W-1:0]   value;
    } t_load;

    typedef struct packed {
        logic start;
        logic shift;
    } t_cell_ctl;

    // Input element travelling down the chain of cells.
    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   idx;
        logic [VAL_W-1:0]   x;
    } t_token;

    // round(2^(k/16) * 65536) for k = 0..16.
    function automatic logic [17:0] pow2_tab(input logic [4:0] k);
        logic [17:0] v;
        case (k)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88752;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110218;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            5'd16:   v = 18'd131072;
            default: v = 18'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/dls_cell.sv =====
// One neuron cell: its weight slice, bias, multiplier and accumulator.
module dls_cell #(
    parameter int CELL_ID = 0,
    parameter int INPUTS  = dls_pkg::INPUTS_DEF,
    parameter int ACC_W   = 40
) (
    input  logic                i_clk,
    input  dls_pkg::t_load      i_ld,
    input  dls_pkg::t_cell_ctl  i_ctl,
    input  dls_pkg::t_token     i_tok,
    output dls_pkg::t_token     o_tok,
    input  logic [ACC_W-1:0]    i_acc,
    output logic [ACC_W-1:0]    o_acc
);

    localparam int IW   = (INPUTS > 1) ? $clog2(INPUTS) : 1;
    localparam int BASE = CELL_ID * INPUTS;

    logic [dls_pkg::VAL_W-1:0] w_mem [INPUTS];
    logic [dls_pkg::VAL_W-1:0] r_bias;
    logic [dls_pkg::VAL_W-1:0] r_w;
    logic [dls_pkg::VAL_W-1:0] r_x;
    logic                      r_va;
    logic [31:0]               r_prod;
    logic                      r_vb;
    logic [ACC_W-1:0]          r_acc;
    dls_pkg::t_token           r_tok;
    logic [23:0]               w_off;
    logic                      w_hit;

    assign w_off = 24'(i_ld.index) - 24'(BASE);
    assign w_hit = (24'(i_ld.index) >= 24'(BASE)) && (24'(i_ld.index) < 24'(BASE + INPUTS));

    always_ff @(posedge i_clk) begin
        if (i_ld.wen_w && w_hit) begin
            w_mem[w_off[IW-1:0]] <= i_ld.value;
        end
        if (i_ld.wen_b && (i_ld.index == dls_pkg::IDX_W'(CELL_ID))) begin
            r_bias <= i_ld.value;
        end
        r_w    <= w_mem[i_tok.idx[IW-1:0]];
        r_x    <= i_tok.x;
        r_prod <= 32'($signed(r_x) * $signed(r_w));
        r_tok  <= i_tok;
        if (i_ctl.start) begin
            r_acc <= ACC_W'($signed(r_bias)) <<< 12;
        end else if (i_ctl.shift) begin
            r_acc <= i_acc;
        end else if (r_vb) begin
            r_acc <= r_acc + ACC_W'($signed(r_prod));
        end
    end

    // Valid flags of the multiply stages are control and are cleared by start.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_tok.valid;
            r_vb <= r_va;
        end
    end

    assign o_tok = r_tok;
    assign o_acc = r_acc;

endmodule

// ===== rtl/dls_exp.sv =====
// Pipelined logit saturation and fixed-point exp.
module dls_exp #(
    parameter int ACC_W = 40
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [ACC_W-1:0]            i_acc,
    output logic                        o_valid,
    output logic [dls_pkg::LOGIT_W-1:0] o_logit,
    output logic [dls_pkg::EXP_W-1:0]   o_exp
);

    logic [3:0]                  r_v;
    logic signed [23:0]          r1_logit;
    logic signed [23:0]          r2_logit;
    logic signed [41:0]          r2_t;
    logic signed [23:0]          r3_logit;
    logic [36:0]                 r3_prod;
    logic [17:0]                 r3_base;
    logic signed [13:0]          r3_n;
    logic [23:0]                 r4_logit;
    logic [31:0]                 r4_exp;

    logic signed [ACC_W-1:0]     w_q;
    logic signed [23:0]          w_sat;
    logic [4:0]                  w_k;
    logic [17:0]                 w_diff;
    logic [17:0]                 w_v;
    logic [32:0]                 w_up;
    logic [13:0]                 w_m;
    logic [31:0]                 w_exp;

    always_comb begin
        w_q = $signed(i_acc) >>> 12;
        if (w_q > $signed(ACC_W'(8388607))) begin
            w_sat = 24'sh7FFFFF;
        end else if (w_q < -$signed(ACC_W'(8388608))) begin
            w_sat = -24'sh800000;
        end else begin
            w_sat = w_q[23:0];
        end
        w_k    = {1'b0, r2_t[27:24]};
        w_diff = dls_pkg::pow2_tab(w_k + 5'd1) - dls_pkg::pow2_tab(w_k);
        w_v    = r3_base + 18'(r3_prod[36:24]);
        w_up   = 33'(w_v) << r3_n[3:0];
        w_m    = 14'(-r3_n);
        if (r3_n >= 14'sd16) begin
            w_exp = 32'hFFFF_FFFF;
        end else if (r3_n >= 14'sd0) begin
            w_exp = w_up[32] ? 32'hFFFF_FFFF : w_up[31:0];
        end else if (w_m >= 14'd17) begin
            w_exp = 32'd0;
        end else begin
            w_exp = 32'(w_v >> w_m[4:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r1_logit <= w_sat;
        r2_logit <= r1_logit;
        r2_t     <= r1_logit * $signed({1'b0, dls_pkg::LOG2E_Q16});
        r3_logit <= r2_logit;
        r3_n     <= r2_t[41:28];
        r3_base  <= dls_pkg::pow2_tab({1'b0, r2_t[27:24]});
        r3_prod  <= 37'(w_diff[12:0] * r2_t[23:0]);
        r4_logit <= r3_logit;
        r4_exp   <= w_exp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    assign o_valid = r_v[3];
    assign o_logit = r4_logit;
    assign o_exp   = r4_exp;

endmodule

// ===== rtl/dls_div.sv =====
// Restoring divider for (exp << 16) / total, one quotient bit per cycle.
module dls_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dls_pkg::EXP_W-1:0]   i_num,
    input  logic [dls_pkg::TOTAL_W-1:0] i_den,
    output logic                        o_done,
    output logic [dls_pkg::PROB_W-1:0]  o_quot
);

    logic [40:0] r_rem;
    logic [16:0] r_bits;
    logic [16:0] r_q;
    logic [39:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [15:0] r_res;
    logic [40:0] w_sh;
    logic        w_ge;
    logic [16:0] w_q;

    // The quotient never exceeds 2^16 since exp <= total, so 17 steps suffice.
    assign w_sh = {r_rem[39:0], r_bits[16]};
    assign w_ge = w_sh >= {1'b0, r_den};
    assign w_q  = {r_q[15:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {10'd0, i_num[31:1]};
            r_bits <= {i_num[0], 16'd0};
            r_q    <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
            r_bits <= {r_bits[15:0], 1'b0};
            r_q    <= w_q;
            if (r_cnt == 5'd1) begin
                if (r_den == '0) begin
                    r_res <= '0;
                end else if (w_q[16]) begin
                    r_res <= 16'hFFFF;
                end else begin
                    r_res <= w_q[15:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd17;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_res;

endmodule

// ===== rtl/dense_layer_softmax_unit.sv =====
// Top level: fully connected layer with softmax over a chain of neuron cells.
//
//  channel  dir  handshake                       contents
//  s_axis   in   s_axis_tvalid / s_axis_tready   load weight, load bias or input element
//  m_axis   out  m_axis_tvalid / m_axis_tready   one result per neuron, neuron order
//
// The input element with tlast starts the layer. The element stream passes down the
// cells, one hop a cycle; the accumulators are then shifted out through the exp
// pipeline. Each result then goes through the bit-serial divider, one at a time.
// Input is refused until the last result is in the output register; a stalled
// output holds its transaction. Reset is synchronous and clears control only.
module dense_layer_softmax_unit #(
    parameter int OUTPUTS = dls_pkg::OUTPUTS_DEF,
    parameter int INPUTS  = dls_pkg::INPUTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // index[9:0], value[25:10], zeros[31:26]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // neuron[3:0], probability[19:4], logit[43:20]
    output logic        m_axis_tlast
);

    localparam int IW    = (INPUTS > 1) ? $clog2(INPUTS) : 1;
    localparam int OW    = $clog2(OUTPUTS);
    localparam int OW1   = $clog2(OUTPUTS + 1);
    localparam int ACC_W = 33 + $clog2(INPUTS + 1);
    localparam int CW    = $clog2(INPUTS + OUTPUTS + 5);

    dls_pkg::t_state     r_state, n_state;
    dls_pkg::t_load      w_ld;
    dls_pkg::t_cell_ctl  w_ctl;
    dls_pkg::t_action    w_act;
    dls_pkg::t_token     w_tok [OUTPUTS+1];
    logic [ACC_W-1:0]    w_acc [OUTPUTS+1];

    logic [15:0]         vec_mem [INPUTS];
    logic [31:0]         exp_mem [OUTPUTS];
    logic [23:0]         lgt_mem [OUTPUTS];

    logic [CW-1:0]       r_cnt;
    logic [OW1-1:0]      r_wcnt;
    logic [OW-1:0]       r_ncnt;
    logic [15:0]         r_x;
    logic                r_tv;
    logic [9:0]          r_ti;
    logic [39:0]         r_total;
    logic [31:0]         r_rd_exp;
    logic [23:0]         r_rd_logit;
    logic                r_m_valid;
    logic [47:0]         r_m_data;
    logic                r_m_last;

    logic                w_acc_in;
    logic                w_start;
    logic                w_load_out;
    logic                w_ev;
    logic [23:0]         w_elogit;
    logic [31:0]         w_eexp;
    logic                w_div_start;
    logic                w_div_done;
    logic [15:0]         w_quot;

    assign w_act    = dls_pkg::t_action'(s_axis_tuser);
    assign w_acc_in = s_axis_tvalid && s_axis_tready;
    assign w_start  = w_acc_in && (w_act == dls_pkg::ACT_ELEM) && s_axis_tlast;

    assign w_ld.wen_w = w_acc_in && (w_act == dls_pkg::ACT_WEIGHT);
    assign w_ld.wen_b = w_acc_in && (w_act == dls_pkg::ACT_BIAS);
    assign w_ld.index = s_axis_tdata[9:0];
    assign w_ld.value = s_axis_tdata[25:10];

    assign w_ctl.start = w_start;
    assign w_ctl.shift = (r_state == dls_pkg::ST_SHIFT);

    assign w_tok[0].valid = r_tv;
    assign w_tok[0].idx   = r_ti;
    assign w_tok[0].x     = r_x;
    assign w_acc[OUTPUTS] = '0;

    for (genvar g = 0; g < OUTPUTS; g++) begin : g_cell
        dls_cell #(
            .CELL_ID (g),
            .INPUTS  (INPUTS),
            .ACC_W   (ACC_W)
        ) u_cell (
            .i_clk (i_clk),
            .i_ld  (w_ld),
            .i_ctl (w_ctl),
            .i_tok (w_tok[g]),
            .o_tok (w_tok[g+1]),
            .i_acc (w_acc[g+1]),
            .o_acc (w_acc[g])
        );
    end

    dls_exp #(
        .ACC_W (ACC_W)
    ) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ctl.shift),
        .i_acc   (w_acc[0]),
        .o_valid (w_ev),
        .o_logit (w_elogit),
        .o_exp   (w_eexp)
    );

    dls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_rd_exp),
        .i_den   (r_total),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dls_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_div_start   = 1'b0;
        w_load_out    = 1'b0;
        case (r_state)
            dls_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (w_start) begin
                    n_state = dls_pkg::ST_MAC;
                end
            end
            dls_pkg::ST_MAC: begin
                if (r_cnt == CW'(INPUTS + OUTPUTS + 4)) begin
                    n_state = dls_pkg::ST_SHIFT;
                end
            end
            dls_pkg::ST_SHIFT: begin
                if (r_cnt == CW'(OUTPUTS - 1)) begin
                    n_state = dls_pkg::ST_DRAIN;
                end
            end
            dls_pkg::ST_DRAIN: begin
                if (r_wcnt == OW1'(OUTPUTS)) begin
                    n_state = dls_pkg::ST_RD;
                end
            end
            dls_pkg::ST_RD: begin
                n_state = dls_pkg::ST_RDW;
            end
            dls_pkg::ST_RDW: begin
                w_div_start = 1'b1;
                n_state     = dls_pkg::ST_DIV;
            end
            dls_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = dls_pkg::ST_OUT;
                end
            end
            dls_pkg::ST_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = (r_ncnt == OW'(OUTPUTS - 1)) ? dls_pkg::ST_IDLE
                                                               : dls_pkg::ST_RD;
                end
            end
            default: begin
                n_state = dls_pkg::ST_IDLE;
            end
        endcase
    end

    // Memories and payload registers.
    always_ff @(posedge i_clk) begin
        if (w_acc_in && (w_act == dls_pkg::ACT_ELEM)
                && (s_axis_tdata[9:0] < 10'(INPUTS))) begin
            vec_mem[s_axis_tdata[IW-1:0]] <= s_axis_tdata[25:10];
        end
        r_x  <= vec_mem[r_cnt[IW-1:0]];
        r_ti <= 10'(r_cnt);
        if (w_ev) begin
            exp_mem[r_wcnt[OW-1:0]] <= w_eexp;
            lgt_mem[r_wcnt[OW-1:0]] <= w_elogit;
        end
        r_rd_exp   <= exp_mem[r_ncnt];
        r_rd_logit <= lgt_mem[r_ncnt];
        if (w_start) begin
            r_total <= '0;
        end else if (w_ev) begin
            r_total <= r_total + 40'(w_eexp);
        end
        if (w_load_out) begin
            r_m_data <= {4'd0, r_rd_logit, w_quot, 4'(r_ncnt)};
            r_m_last <= (r_ncnt == OW'(OUTPUTS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_wcnt    <= '0;
            r_ncnt    <= '0;
            r_tv      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_tv <= (r_state == dls_pkg::ST_MAC) && (r_cnt < CW'(INPUTS));
            if (w_start || (r_state != n_state)) begin
                r_cnt <= '0;
            end else if ((r_state == dls_pkg::ST_MAC) || (r_state == dls_pkg::ST_SHIFT)) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (w_start) begin
                r_wcnt <= '0;
            end else if (w_ev) begin
                r_wcnt <= r_wcnt + OW1'(1);
            end
            if (w_start) begin
                r_ncnt <= '0;
            end else if (w_load_out) begin
                r_ncnt <= r_ncnt + OW'(1);
            end
            if (w_load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == dls_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

    a_exp_in_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ev |-> ((r_state == dls_pkg::ST_SHIFT) || (r_state == dls_pkg::ST_DRAIN)))
        else $error("exp result outside the shift and drain phases");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && (r_ncnt == OW'(OUTPUTS - 1))) |=> (r_state == dls_pkg::ST_IDLE))
        else $error("last result did not return the block to idle");

endmodule

// ===== dv/dense_layer_softmax_unit_checker.sv =====
// Checker for the dense layer with softmax: predicts each layer run and compares results.
module dense_layer_softmax_unit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_in_data,   // index[9:0], value[25:10], zeros[31:26]
    input  logic [1:0]  i_in_user,   // action[1:0]
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [47:0] i_out_data,  // neuron[3:0], probability[19:4], logit[43:20]
    input  logic        i_out_last,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);

    localparam int NOUT = dls_pkg::OUTPUTS_DEF;
    localparam int NIN  = dls_pkg::INPUTS_DEF;

    typedef struct packed {
        logic [dls_pkg::NRN_W-1:0]   neuron;
        logic [dls_pkg::PROB_W-1:0]  prob;
        logic [dls_pkg::LOGIT_W-1:0] logit;
        logic                        fin;
    } t_result;

    logic [dls_pkg::VAL_W-1:0] weights [NOUT*NIN];
    logic [dls_pkg::VAL_W-1:0] biases [NOUT];
    logic [dls_pkg::VAL_W-1:0] vec [NIN];
    t_result softmax_q [$];

    initial o_errors = 0;
    initial o_results = 0;
    initial o_pending = 0;

    function automatic logic [17:0] seg_val(input int k);
        case (k)
            0: return 18'd65536;    1: return 18'd68438;    2: return 18'd71468;
            3: return 18'd74632;    4: return 18'd77936;    5: return 18'd81386;
            6: return 18'd84990;    7: return 18'd88752;    8: return 18'd92682;
            9: return 18'd96785;    10: return 18'd101070;  11: return 18'd105545;
            12: return 18'd110218;  13: return 18'd115098;  14: return 18'd120194;
            15: return 18'd125515;
            default: return 18'd131072;
        endcase
    endfunction

    function automatic logic [dls_pkg::EXP_W-1:0] exp_q16(
        input logic signed [dls_pkg::LOGIT_W-1:0] x
    );
        logic signed [63:0] t;
        longint n;
        logic [27:0] f;
        int k;
        logic [63:0] v;
        logic [63:0] s;
        t = 64'(x) * 64'sd94548;
        n = t >>> 28;
        f = t[27:0];
        k = int'(f[27:24]);
        v = 64'(seg_val(k))
            + (((64'(seg_val(k + 1)) - 64'(seg_val(k))) * 64'(f[23:0])) >> 24);
        if (n >= 16) return '1;
        if (n >= 0) begin
            s = v << n;
            return (s > 64'hFFFF_FFFF) ? '1 : s[31:0];
        end
        if (-n >= 17) return '0;
        return dls_pkg::EXP_W'(v >> (-n));
    endfunction

    task automatic predict_layer();
        logic signed [63:0] acc;
        logic signed [63:0] q;
        logic [dls_pkg::LOGIT_W-1:0] lg [NOUT];
        logic [dls_pkg::EXP_W-1:0] ex [NOUT];
        logic [dls_pkg::TOTAL_W-1:0] total;
        logic [63:0] p;
        t_result r;
        total = '0;
        for (int n = 0; n < NOUT; n++) begin
            acc = 64'($signed(biases[n])) * 64'sd4096;
            for (int i = 0; i < NIN; i++)
                acc += 64'($signed(vec[i])) * 64'($signed(weights[n*NIN+i]));
            q = acc >>> 12;
            if (q > 64'sd8388607) q = 64'sd8388607;
            if (q < -64'sd8388608) q = -64'sd8388608;
            lg[n] = q[dls_pkg::LOGIT_W-1:0];
            ex[n] = exp_q16(lg[n]);
            total += dls_pkg::TOTAL_W'(ex[n]);
        end
        for (int n = 0; n < NOUT; n++) begin
            p = '0;
            if (total != 0) begin
                p = ({32'd0, ex[n]} << 16) / {24'd0, total};
                if (p > 64'd65535) p = 64'd65535;
            end
            r.neuron = n[dls_pkg::NRN_W-1:0];
            r.prob = p[15:0];
            r.logit = lg[n];
            r.fin = (n == NOUT - 1);
            softmax_q.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        dls_pkg::t_action act;
        logic [dls_pkg::IDX_W-1:0] idx;
        logic [dls_pkg::VAL_W-1:0] val;
        t_result got;
        t_result want;
        if (i_rst_n && i_in_valid && i_in_ready) begin
            act = dls_pkg::t_action'(i_in_user);
            idx = i_in_data[9:0];
            val = i_in_data[25:10];
            case (act)
                dls_pkg::ACT_WEIGHT: if (idx < NOUT*NIN) weights[idx] = val;
                dls_pkg::ACT_BIAS: if (idx < NOUT) biases[idx] = val;
                dls_pkg::ACT_ELEM: begin
                    if (idx < NIN) vec[idx] = val;
                    if (i_in_last) predict_layer();
                end
                default: ;
            endcase
        end
        if (i_rst_n && i_out_valid && i_out_ready) begin
            got.neuron = i_out_data[3:0];
            got.prob = i_out_data[19:4];
            got.logit = i_out_data[43:20];
            got.fin = i_out_last;
            o_results <= o_results + 1;
            if (softmax_q.size() == 0) begin
                if (o_errors < 10) $display("unexpected result %h", got);
                o_errors <= o_errors + 1;
            end else begin
                want = softmax_q.pop_front();
                if (got !== want) begin
                    if (o_errors < 10)
                        $display("mismatch: neuron %0d/%0d prob %0d/%0d logit %h/%h last %b/%b",
                            want.neuron, got.neuron, want.prob, got.prob,
                            want.logit, got.logit, want.fin, got.fin);
                    o_errors <= o_errors + 1;
                end
            end
        end
        o_pending <= softmax_q.size();
    end

endmodule

// ===== dv/dense_layer_softmax_unit_test.sv =====
// Testbench top: drives load and element transactions and gives the verdict.
module dense_layer_softmax_unit_test;

    localparam int NOUT = dls_pkg::OUTPUTS_DEF;
    localparam int NIN  = dls_pkg::INPUTS_DEF;
    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data;
    logic [1:0]  s_user;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [47:0] m_data;
    logic        m_last;
    int errors, pending, results, cycles, sent;
    logic hold_off;

    dense_layer_softmax_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
        .s_axis_tdata(s_data), .s_axis_tuser(s_user), .s_axis_tlast(s_last),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
        .m_axis_tdata(m_data), .m_axis_tlast(m_last)
    );

    dense_layer_softmax_unit_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_valid), .i_in_ready(s_ready), .i_in_data(s_data),
        .i_in_user(s_user), .i_in_last(s_last),
        .i_out_valid(m_valid), .i_out_ready(m_ready), .i_out_data(m_data),
        .i_out_last(m_last),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Receiver: stall pattern, plus one long hold-off so the block backs up.
    initial begin
        int phase;
        m_ready = 0;
        hold_off = 0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (hold_off) m_ready <= 0;
            else if (phase % 400 < 150) m_ready <= 1;
            else m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Sends one transaction and waits until it is accepted.
    task automatic send_item(input dls_pkg::t_action act, input logic [9:0] idx,
                             input logic [15:0] val, input logic lst);
        s_valid <= 1;
        s_user <= act;
        s_data <= {6'd0, val, idx};
        s_last <= lst;
        do @(posedge i_clk); while (!s_ready);
        sent++;
        if ($urandom_range(0, 5) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] rand_val(input int mode);
        case (mode)
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 16'h1FFF)) - 16'h1000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_all(input int mode);
        for (int a = 0; a < NOUT*NIN; a++)
            send_item(dls_pkg::ACT_WEIGHT, a[9:0], rand_val(mode),
                      1'($urandom_range(0, 1)));
        for (int n = 0; n < NOUT; n++)
            send_item(dls_pkg::ACT_BIAS, n[9:0], rand_val(mode),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic run_vector(input int mode);
        for (int i = 0; i < NIN; i++)
            send_item(dls_pkg::ACT_ELEM, i[9:0], rand_val(mode), i == NIN - 1);
    endtask

    initial begin
        s_valid = 0; s_data = '0; s_user = dls_pkg::ACT_NONE; s_last = 0; sent = 0;
        i_rst_n = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Every store entry is written before the first layer run.
        load_all(2);
        // Directed: ignored actions, out-of-range indexes, stray last flags.
        send_item(dls_pkg::ACT_NONE, 10'h3FF, 16'hFFFF, 1);
        send_item(dls_pkg::ACT_WEIGHT, 10'h3FF, 16'h8000, 1);
        send_item(dls_pkg::ACT_BIAS, 10'd16, 16'h7FFF, 1);
        send_item(dls_pkg::ACT_BIAS, 10'h3FF, 16'h1234, 0);
        send_item(dls_pkg::ACT_ELEM, 10'd64, 16'h5555, 0);
        send_item(dls_pkg::ACT_ELEM, 10'h3FF, 16'hAAAA, 0);
        run_vector(2);
        // Last on an out-of-range element still starts the layer.
        send_item(dls_pkg::ACT_ELEM, 10'h3FF, 16'h7FFF, 1);
        // Extremes: neuron 0 saturates high, neuron 1 low.
        send_item(dls_pkg::ACT_BIAS, 10'd0, 16'h7FFF, 0);
        send_item(dls_pkg::ACT_BIAS, 10'd1, 16'h8000, 0);
        for (int i = 0; i < 40; i++) begin
            send_item(dls_pkg::ACT_WEIGHT, 10'(i), 16'h7FFF, 0);
            send_item(dls_pkg::ACT_WEIGHT, 10'(NIN + i), 16'h8000, 0);
        end
        for (int i = 0; i < NIN; i++)
            send_item(dls_pkg::ACT_ELEM, i[9:0], 16'h7FFF, i == NIN - 1);
        // Very negative logits everywhere give an exp sum of zero.
        for (int n = 0; n < NOUT; n++) begin
            send_item(dls_pkg::ACT_BIAS, n[9:0], 16'h8000, 0);
            send_item(dls_pkg::ACT_WEIGHT, 10'(n * NIN), 16'h7FFF, 0);
        end
        for (int i = 0; i < NIN; i++)
            send_item(dls_pkg::ACT_ELEM, i[9:0], (i == 0) ? 16'h8000 : 16'h0000,
                      i == NIN - 1);
        // Long hold-off at the receiver while the sender keeps going.
        fork
            begin
                hold_off = 1;
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end
            run_vector(3);
        join
        // Random part: partial reloads then short runs.
        for (int r = 0; r < 6; r++) begin
            for (int j = 0; j < 10; j++) begin
                int kind;
                kind = $urandom_range(0, 9);
                if (kind < 6)
                    send_item(dls_pkg::ACT_WEIGHT, 10'($urandom_range(0, 1023)),
                              rand_val(3), 1'($urandom_range(0, 1)));
                else if (kind < 8)
                    send_item(dls_pkg::ACT_BIAS, 10'($urandom_range(0, 31)),
                              rand_val(2), 1'($urandom_range(0, 1)));
                else if (kind == 8)
                    send_item(dls_pkg::ACT_NONE, 10'($urandom), 16'($urandom),
                              1'($urandom_range(0, 1)));
                else
                    send_item(dls_pkg::ACT_ELEM, 10'($urandom_range(0, 80)),
                              rand_val(2), 0);
            end
            send_item(dls_pkg::ACT_ELEM, 10'($urandom_range(0, 70)),
                      rand_val($urandom_range(0, 3)), 1);
        end
        s_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("sent %0d input transactions, checked %0d results", sent, results);
        $display("covered ignored actions, range checks, logit and exp saturation, "
                 , "zero exp sum, back-pressure");
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
